/* hw/rtl/mlt_pkg.sv */
package mlt_pkg;

  localparam int MAX_LINE_LENGTH  = 4096;
  localparam int LINE_COUNT_WIDTH = 24;
  localparam int COL_W            = 13;
  localparam int HASH_W           = 3;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DATA_W       = 72;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  localparam logic [COL_W-1:0] MAX_COL = COL_W'(MAX_LINE_LENGTH);
  localparam logic [HASH_W-1:0] MAX_HASH = HASH_W'(6);

  typedef enum logic [2:0] {
    PC_START, PC_BSLASH, PC_ESCAPED, PC_GT, PC_QUOTE, PC_HASH, PC_TITLE, PC_TEXT
  } prefix_t;

  typedef enum logic [2:0] {
    LN_EMPTY, LN_ESCAPED, LN_QUOTE, LN_TITLE, LN_TEXT
  } line_kind_t;

  typedef enum logic [2:0] {
    TK_EMPTY   = 3'd0,
    TK_TEXT    = 3'd1,
    TK_QUOTE   = 3'd2,
    TK_SYMBOL  = 3'd3,
    TK_LITERAL = 3'd4
  } token_kind_t;

  // one closed line as handed from the front to the back
  typedef struct packed {
    line_kind_t                  kind;
    logic [LINE_COUNT_WIDTH-1:0] line;
    logic [COL_W-1:0]            last_col;
    logic [HASH_W-1:0]           hashes;
    logic [COL_W-1:0]            lit_col;
    logic                        too_long;
  } line_rec_t;

  typedef struct packed {
    logic             too_long;
    logic [COL_W-1:0] value_length;
    logic [COL_W-1:0] value_start;
    logic [COL_W-1:0] column;
    logic [23:0]      line_number;
    token_kind_t      kind;
  } token_t;

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
  endfunction

endpackage

/* hw/rtl/mlt_front.sv */
module mlt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_eos,
  output logic              push,
  output mlt_pkg::line_rec_t push_rec,
  input  logic              queue_full
);
  import mlt_pkg::*;

  logic [LINE_COUNT_WIDTH-1:0] line_cnt, line_cnt_next;
  logic [COL_W-1:0]            col, col_next;
  prefix_t                     pc, pc_next;
  logic [HASH_W-1:0]           hashes, hashes_next;
  logic                        has_ns, has_ns_next;
  logic [COL_W-1:0]            last_col, last_col_next;
  logic [COL_W-1:0]            lit_col, lit_col_next;
  logic                        prev_empty, prev_empty_next;
  logic                        swallow, swallow_next;
  logic                        ovf, ovf_next;

  // line state after taking the current byte
  logic [COL_W-1:0]  a_col, a_last, a_lit;
  prefix_t           a_pc;
  logic [HASH_W-1:0] a_hash;
  logic              a_hn, a_ovf;
  // line state used to close the line
  logic [COL_W-1:0]  c_last, c_lit;
  prefix_t           c_pc;
  logic [HASH_W-1:0] c_hash;
  logic              c_hn, c_ovf;

  logic accept, is_term, do_close, use_added;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign is_term  = (in_byte == CH_LF) || (in_byte == CH_CR);

  always_comb begin
    a_col  = col;
    a_last = last_col;
    a_lit  = lit_col;
    a_pc   = pc;
    a_hash = hashes;
    a_hn   = has_ns;
    a_ovf  = ovf;
    if (col >= MAX_COL) begin
      a_ovf = 1'b1;
    end else begin
      a_col = col + COL_W'(1);
      if (in_byte != CH_SPACE) a_hn = 1'b1;
      if (!is_blank(in_byte)) a_last = a_col;
      case (pc)
        PC_START: begin
          if (in_byte == CH_BSLASH) a_pc = PC_BSLASH;
          else if (in_byte == CH_GT) a_pc = PC_GT;
          else if (in_byte == CH_HASH) begin
            a_pc   = PC_HASH;
            a_hash = HASH_W'(1);
          end else a_pc = PC_TEXT;
        end
        PC_BSLASH: a_pc = (in_byte == CH_HASH || in_byte == CH_GT) ? PC_ESCAPED : PC_TEXT;
        PC_GT:     a_pc = (in_byte == CH_SPACE) ? PC_QUOTE : PC_TEXT;
        PC_HASH: begin
          if (in_byte == CH_HASH) begin
            if (hashes < MAX_HASH) a_hash = hashes + HASH_W'(1);
            else a_pc = PC_TEXT;
          end else if (in_byte == CH_SPACE) a_pc = PC_TITLE;
          else a_pc = PC_TEXT;
        end
        PC_TITLE: begin
          if (lit_col == '0 && !is_blank(in_byte)) a_lit = a_col;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    use_added = !is_term;
    c_last = use_added ? a_last : last_col;
    c_lit  = use_added ? a_lit  : lit_col;
    c_pc   = use_added ? a_pc   : pc;
    c_hash = use_added ? a_hash : hashes;
    c_hn   = use_added ? a_hn   : has_ns;
    c_ovf  = use_added ? a_ovf  : ovf;
  end

  always_comb begin
    line_cnt_next   = line_cnt;
    col_next        = col;
    pc_next         = pc;
    hashes_next     = hashes;
    has_ns_next     = has_ns;
    last_col_next   = last_col;
    lit_col_next    = lit_col;
    prev_empty_next = prev_empty;
    swallow_next    = swallow;
    ovf_next        = ovf;
    do_close        = 1'b0;
    push            = 1'b0;

    push_rec.line     = line_cnt;
    push_rec.last_col = c_last;
    push_rec.hashes   = c_hash;
    push_rec.lit_col  = c_lit;
    push_rec.too_long = c_ovf;
    case (c_pc)
      PC_ESCAPED: push_rec.kind = LN_ESCAPED;
      PC_QUOTE:   push_rec.kind = LN_QUOTE;
      PC_TITLE:   push_rec.kind = LN_TITLE;
      default:    push_rec.kind = LN_TEXT;
    endcase
    if (!c_hn) push_rec.kind = LN_EMPTY;

    if (accept) begin
      if (in_byte == CH_LF && swallow) begin
        swallow_next = 1'b0;
      end else if (is_term) begin
        do_close     = 1'b1;
        swallow_next = (in_byte == CH_CR);
        if (line_cnt != '1) line_cnt_next = line_cnt + LINE_COUNT_WIDTH'(1);
      end else begin
        swallow_next  = 1'b0;
        col_next      = a_col;
        pc_next       = a_pc;
        hashes_next   = a_hash;
        has_ns_next   = a_hn;
        last_col_next = a_last;
        lit_col_next  = a_lit;
        ovf_next      = a_ovf;
        do_close      = in_eos;
      end

      if (do_close) begin
        if (!c_hn) begin
          // collapse runs of empty lines into one token
          if (!prev_empty) push = 1'b1;
          prev_empty_next = 1'b1;
        end else begin
          push            = 1'b1;
          prev_empty_next = 1'b0;
        end
      end

      if (do_close || in_eos) begin
        col_next      = '0;
        pc_next       = PC_START;
        hashes_next   = '0;
        has_ns_next   = 1'b0;
        last_col_next = '0;
        lit_col_next  = '0;
        ovf_next      = 1'b0;
      end

      if (in_eos) begin
        line_cnt_next   = LINE_COUNT_WIDTH'(1);
        prev_empty_next = 1'b0;
        swallow_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_cnt   <= LINE_COUNT_WIDTH'(1);
      col        <= '0;
      pc         <= PC_START;
      hashes     <= '0;
      has_ns     <= 1'b0;
      last_col   <= '0;
      lit_col    <= '0;
      prev_empty <= 1'b0;
      swallow    <= 1'b0;
      ovf        <= 1'b0;
    end else begin
      line_cnt   <= line_cnt_next;
      col        <= col_next;
      pc         <= pc_next;
      hashes     <= hashes_next;
      has_ns     <= has_ns_next;
      last_col   <= last_col_next;
      lit_col    <= lit_col_next;
      prev_empty <= prev_empty_next;
      swallow    <= swallow_next;
      ovf        <= ovf_next;
    end
  end

endmodule

/* hw/rtl/mlt_queue.sv */
module mlt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mlt_pkg::line_rec_t push_rec,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output mlt_pkg::line_rec_t head
);
  import mlt_pkg::*;

  line_rec_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push, do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

endmodule

/* hw/rtl/mlt_back.sv */
module mlt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  input  mlt_pkg::line_rec_t rec,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output mlt_pkg::token_t    out_tok,
  output logic               out_last
);
  import mlt_pkg::*;

  logic             second, second_next;
  logic             load;
  logic             last_tok;
  token_t           tok;
  logic [COL_W-1:0] lit_start;

  assign load      = rec_valid && (!out_valid || out_ready);
  assign lit_start = COL_W'(rec.hashes) + COL_W'(2);

  always_comb begin
    tok.too_long     = rec.too_long;
    tok.line_number  = 24'(rec.line);
    tok.kind         = TK_TEXT;
    tok.column       = COL_W'(1);
    tok.value_start  = COL_W'(1);
    tok.value_length = rec.last_col;
    last_tok         = 1'b1;
    case (rec.kind)
      LN_EMPTY: begin
        tok.kind         = TK_EMPTY;
        tok.value_length = '0;
      end
      LN_ESCAPED: begin
        tok.value_start  = COL_W'(2);
        tok.value_length = (rec.last_col >= COL_W'(2)) ? rec.last_col - COL_W'(1) : '0;
      end
      LN_QUOTE: begin
        tok.kind         = TK_QUOTE;
        tok.column       = COL_W'(3);
        tok.value_start  = COL_W'(3);
        tok.value_length = (rec.last_col >= COL_W'(3)) ? rec.last_col - COL_W'(2) : '0;
      end
      LN_TITLE: begin
        if (!second) begin
          tok.kind         = TK_SYMBOL;
          tok.value_length = COL_W'(rec.hashes);
          last_tok         = 1'b0;
        end else begin
          tok.kind   = TK_LITERAL;
          tok.column = lit_start;
          // blank literal points at its own column with no bytes
          if (rec.lit_col == '0 || rec.last_col < rec.lit_col) begin
            tok.value_start  = lit_start;
            tok.value_length = '0;
          end else begin
            tok.value_start  = rec.lit_col;
            tok.value_length = rec.last_col - rec.lit_col + COL_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    second_next = second;
    pop         = 1'b0;
    if (load) begin
      if (last_tok) begin
        pop         = 1'b1;
        second_next = 1'b0;
      end else begin
        second_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      second <= second_next;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= tok;
      out_last <= last_tok;
    end
  end

endmodule

/* hw/rtl/markdown_line_tokenizer_core.sv */
// Markdown line tokenizer: takes one source byte per cycle on the s_ side
// (tlast marks the final byte of a source) and emits token items on the m_
// side. The front classifies bytes as they arrive and, at each line end,
// pushes one line record into a four-entry queue (a run of empty lines gives
// one); the back turns each record into one token, or two for a title line,
// one per cycle through an output register while m_tready holds. A new byte
// is taken every cycle while the queue has room, so the sustained rate is one
// byte per cycle while the m_ side keeps up. A record is written to the queue
// at the edge that takes its closing byte, and its first token is registered
// once the output register is free. Title lines give two tokens, which the
// queue absorbs since a title line spans at least two bytes.
module markdown_line_tokenizer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // data_byte
  input  logic                           s_tlast,  // end_of_source
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // token_kind[2:0], line_number[26:3], column[39:27], value_start[52:40],
  // value_length[65:53], line_too_long[66], zero fill [71:67]
  output logic [mlt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast   // last_of_run
);
  import mlt_pkg::*;

  logic      push, full, pop, not_empty;
  line_rec_t push_rec, head;
  token_t    tok;

  mlt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_eos     (s_tlast),
    .push       (push),
    .push_rec   (push_rec),
    .queue_full (full)
  );

  mlt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  mlt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (not_empty),
    .rec       (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tok   (tok),
    .out_last  (m_tlast)
  );

  assign m_tdata = {5'b0, tok};

endmodule

/* bench/token_stream_checker.sv */
`timescale 1ns / 1ps

module token_stream_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // data_byte
  input  logic                           s_tlast,  // end_of_source
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // token_kind, line_number, column, value_start, value_length, line_too_long,
  // zero fill
  input  logic [mlt_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           m_tlast,  // last_of_run
  output int                             fail_count,
  output int                             pending,
  output int                             bytes_seen,
  output int                             tokens_seen,
  output int                             long_tokens
);
  import mlt_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic   last;
    token_t tok;
  } token_exp_t;

  token_exp_t expected_tokens[$];

  // tokenizer state as the block should hold it
  logic [LINE_COUNT_WIDTH-1:0] line_no;
  int                          col_no;
  prefix_t                     prefix;
  int                          hashes;
  bit                          saw_nonspace;
  int                          ink_col;
  int                          lit_col;
  bit                          prev_empty;
  bit                          drop_lf;
  bit                          spilled;

  function automatic bit blank_byte(input logic [7:0] b);
    case (b)
      CH_SPACE, CH_TAB, CH_VT, CH_FF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_line_state();
    col_no       = 0;
    prefix       = PC_START;
    hashes       = 0;
    saw_nonspace = 1'b0;
    ink_col      = 0;
    lit_col      = 0;
    spilled      = 1'b0;
  endtask

  task automatic restart_source();
    clear_line_state();
    line_no    = 1;
    prev_empty = 1'b0;
    drop_lf    = 1'b0;
  endtask

  task automatic push_token(input token_kind_t kind, input int col, input int vstart,
                            input int vlen);
    token_exp_t e;
    e.last             = 1'b0;
    e.tok.kind         = kind;
    e.tok.line_number  = 24'(line_no);
    e.tok.column       = COL_W'(col);
    e.tok.value_start  = COL_W'(vstart);
    e.tok.value_length = COL_W'(vlen);
    e.tok.too_long     = spilled;
    expected_tokens.insert(expected_tokens.size(), e);
  endtask

  task automatic close_line_tokens();
    if (!saw_nonspace) begin
      // collapse runs of empty lines into one token
      if (!prev_empty) begin
        prev_empty = 1'b1;
        push_token(TK_EMPTY, 1, 1, 0);
      end
      return;
    end
    prev_empty = 1'b0;
    case (prefix)
      PC_ESCAPED: push_token(TK_TEXT, 1, 2, (ink_col >= 2) ? ink_col - 1 : 0);
      PC_QUOTE:   push_token(TK_QUOTE, 3, 3, (ink_col >= 3) ? ink_col - 2 : 0);
      PC_TITLE: begin
        push_token(TK_SYMBOL, 1, 1, hashes);
        if (lit_col == 0 || ink_col < lit_col) begin
          push_token(TK_LITERAL, hashes + 2, hashes + 2, 0);
        end else begin
          push_token(TK_LITERAL, hashes + 2, lit_col, ink_col - lit_col + 1);
        end
      end
      default: push_token(TK_TEXT, 1, 1, ink_col);
    endcase
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    // drop bytes past the bound, only flag them
    if (col_no >= MAX_LINE_LENGTH) begin
      spilled = 1'b1;
      return;
    end
    col_no++;
    if (b != CH_SPACE) saw_nonspace = 1'b1;
    if (!blank_byte(b)) ink_col = col_no;
    case (prefix)
      PC_START: begin
        if (b == CH_BSLASH) prefix = PC_BSLASH;
        else if (b == CH_GT) prefix = PC_GT;
        else if (b == CH_HASH) begin
          prefix = PC_HASH;
          hashes = 1;
        end else prefix = PC_TEXT;
      end
      PC_BSLASH: prefix = (b == CH_HASH || b == CH_GT) ? PC_ESCAPED : PC_TEXT;
      PC_GT:     prefix = (b == CH_SPACE) ? PC_QUOTE : PC_TEXT;
      PC_HASH: begin
        if (b == CH_HASH) begin
          if (hashes < MAX_HASH) hashes++;
          else prefix = PC_TEXT;
        end else if (b == CH_SPACE) prefix = PC_TITLE;
        else prefix = PC_TEXT;
      end
      PC_TITLE: begin
        if (lit_col == 0 && !blank_byte(b)) lit_col = col_no;
      end
      default: ;
    endcase
  endtask

  task automatic tokenize_byte(input logic [7:0] b, input logic eos);
    int         queued;
    token_exp_t tail;
    queued = expected_tokens.size();
    if (b == CH_LF && drop_lf) begin
      drop_lf = 1'b0;
    end else if (b == CH_LF || b == CH_CR) begin
      close_line_tokens();
      drop_lf = (b == CH_CR);
      if (line_no != '1) line_no++;
      clear_line_state();
    end else begin
      drop_lf = 1'b0;
      absorb_byte(b);
      if (eos) begin
        close_line_tokens();
        clear_line_state();
      end
    end
    if (eos) restart_source();
    // mark the final token caused by this item
    if (expected_tokens.size() > queued) begin
      tail      = expected_tokens[expected_tokens.size() - 1];
      tail.last = 1'b1;
      expected_tokens[expected_tokens.size() - 1] = tail;
    end
  endtask

  always @(posedge clk) begin
    token_exp_t want;
    token_t     got;
    logic       bad;
    if (rst) begin
      restart_source();
      expected_tokens.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        bytes_seen++;
        tokenize_byte(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        got = token_t'(m_tdata[$bits(token_t)-1:0]);
        tokens_seen++;
        if (got.too_long === 1'b1) long_tokens++;
        if (expected_tokens.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("token %0d arrived with none expected: kind %0d line %0d col %0d",
                     tokens_seen, got.kind, got.line_number, got.column);
          end
        end else begin
          want = expected_tokens.pop_front();
          bad  = (got.kind !== want.tok.kind) ||
                 (got.line_number !== want.tok.line_number) ||
                 (got.column !== want.tok.column) ||
                 (got.value_start !== want.tok.value_start) ||
                 (got.value_length !== want.tok.value_length) ||
                 (got.too_long !== want.tok.too_long) ||
                 (m_tlast !== want.last);
          if (bad) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("token %0d mismatch: expected kind %0d line %0d col %0d start %0d",
                       tokens_seen, want.tok.kind, want.tok.line_number,
                       want.tok.column, want.tok.value_start);
              $display("  len %0d long %0b last %0b; actual kind %0d line %0d col %0d",
                       want.tok.value_length, want.tok.too_long, want.last,
                       got.kind, got.line_number, got.column);
              $display("  start %0d len %0d long %0b last %0b",
                       got.value_start, got.value_length, got.too_long, m_tlast);
            end
          end
        end
      end
    end
    pending = expected_tokens.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mlt_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_BYTES   = 250;
  localparam int HOLD_CYCLES   = 80;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  int fail_count;
  int pending;
  int bytes_seen;
  int tokens_seen;
  int long_tokens;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_left    = 0;
  int phase_bytes  = 0;
  int sources_sent = 0;

  logic [7:0] src_bytes[$];

  always #6 clk = ~clk;

  markdown_line_tokenizer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  token_stream_checker i_token_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .pending     (pending),
    .bytes_seen  (bytes_seen),
    .tokens_seen (tokens_seen),
    .long_tokens (long_tokens)
  );

  // receiver: random stalls, or a long hold-off counted down here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("markdown_line_tokenizer_core regression: fail");
    $finish;
  end

  function automatic logic [7:0] body_byte();
    case ($urandom_range(7))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return $urandom_range(1) ? CH_VT : CH_FF;
      3: return CH_HASH;
      4: return CH_GT;
      5: return CH_BSLASH;
      default: return 8'($urandom_range(8'h21, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] marker_byte();
    case ($urandom_range(3))
      0: return CH_HASH;
      1: return CH_GT;
      2: return CH_BSLASH;
      default: return CH_SPACE;
    endcase
  endfunction

  task automatic append_byte(input logic [7:0] b);
    src_bytes.insert(src_bytes.size(), b);
  endtask

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    phase_bytes++;
  endtask

  task automatic send_source();
    for (int i = 0; i < src_bytes.size(); i++) begin
      send_item(src_bytes[i], i == src_bytes.size() - 1);
    end
    src_bytes.delete();
    sources_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_body();
    repeat ($urandom_range(0, 10)) append_byte(body_byte());
  endtask

  task automatic add_terminator();
    case ($urandom_range(2))
      0: append_byte(CH_LF);
      1: append_byte(CH_CR);
      default: begin
        append_byte(CH_CR);
        append_byte(CH_LF);
      end
    endcase
  endtask

  task automatic random_line();
    case ($urandom_range(10))
      0: repeat ($urandom_range(0, 3)) append_byte(CH_SPACE);
      1: begin
        append_byte(CH_BSLASH);
        append_byte($urandom_range(1) ? CH_HASH : CH_GT);
        add_body();
      end
      2: begin
        append_byte(CH_GT);
        append_byte(CH_SPACE);
        add_body();
      end
      3, 4: begin
        repeat ($urandom_range(1, 6)) append_byte(CH_HASH);
        append_byte(CH_SPACE);
        add_body();
      end
      5: begin
        // near-miss prefixes
        repeat ($urandom_range(1, 8)) append_byte(marker_byte());
        add_body();
      end
      6: begin
        repeat (7) append_byte(CH_HASH);
        append_byte(CH_SPACE);
        add_body();
      end
      7, 8: add_body();
      9: repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(255)));
      default: begin
        repeat ($urandom_range(1, 4)) begin
          append_byte(($urandom_range(1) != 0) ? CH_SPACE : body_byte());
        end
      end
    endcase
  endtask

  task automatic random_source();
    int lines;
    lines = $urandom_range(1, 6);
    for (int n = 0; n < lines; n++) begin
      random_line();
      if (n < lines - 1 || $urandom_range(1) != 0) add_terminator();
    end
    if (src_bytes.size() == 0) append_byte(8'($urandom_range(255)));
    send_source();
  endtask

  task automatic random_phase(input int idle, input int stall);
    idle_pct    = idle;
    stall_pct   = stall;
    phase_bytes = 0;
    while (phase_bytes < PHASE_BYTES) random_source();
    drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty, collapsed empty, escape with CR LF, quote ending in CR,
    // title with blank literal, text closed by end of source on 0x00
    src_bytes = '{CH_LF, CH_SPACE, CH_LF,
                  CH_BSLASH, CH_HASH, CH_CR, CH_LF,
                  CH_GT, CH_SPACE, 8'h71, CH_CR,
                  CH_HASH, CH_HASH, CH_SPACE, CH_TAB, CH_LF,
                  CH_HASH, 8'hFF, 8'h00};
    send_source();
    // end of source on a swallowed LF, then on a CR, then a one-byte source
    src_bytes = '{CH_CR, CH_LF};
    send_source();
    src_bytes = '{CH_CR};
    send_source();
    src_bytes = '{8'h78};
    send_source();
    drain();

    random_phase(0, 0);
    random_phase(76, 0);
    random_phase(0, 76);
    random_phase(37, 37);

    // hold off the receiver while short lines keep coming, so the block backs up
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (24) begin
      append_byte(8'h61);
      append_byte(CH_LF);
    end
    send_source();
    drain();

    // a title line that runs through the bound and past it
    stall_pct = 20;
    append_byte(CH_HASH);
    append_byte(CH_HASH);
    append_byte(CH_SPACE);
    repeat (MAX_LINE_LENGTH + $urandom_range(1, 40)) append_byte(body_byte());
    append_byte(CH_CR);
    send_source();
    drain();

    $display("run covered %0d bytes in %0d sources and %0d checked tokens, %0d from long lines",
             bytes_seen, sources_sent, tokens_seen, long_tokens);
    if (fail_count == 0 && pending == 0) begin
      $display("markdown_line_tokenizer_core regression: pass");
    end else begin
      $display("markdown_line_tokenizer_core regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mlt_pkg.sv
hw/rtl/mlt_front.sv
hw/rtl/mlt_queue.sv
hw/rtl/mlt_back.sv
hw/rtl/markdown_line_tokenizer_core.sv
bench/token_stream_checker.sv
bench/testbench.sv
